// File: rtl/mng_pkg.sv
package mng_pkg;

	localparam int unsigned RateFracBits = 24;
	localparam int unsigned ThrW = 16;
	localparam int unsigned SampleW = 16;
	localparam int unsigned MagW = SampleW + 1;
	localparam int unsigned FrameW = 32;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [ThrW-1:0] ThrReset = 16'd400;
	localparam logic [RateFracBits-1:0] AttackReset = 24'd335544;
	localparam logic [RateFracBits-1:0] ReleaseReset = 24'd8389;

	typedef enum logic [CfgIdxW-1:0] {
		REG_THRESHOLD = 2'd0,
		REG_ATTACK    = 2'd1,
		REG_RELEASE   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [ThrW-1:0]         threshold;
		logic [RateFracBits-1:0] attack_rate;
		logic [RateFracBits-1:0] release_rate;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mult_stat_t;

endpackage

// File: rtl/mng_cfg.sv
module mng_cfg
	import mng_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CfgIdxW-1:0]      cfg_index,
	input  logic [RateFracBits-1:0] cfg_data,
	output cfg_t                    cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= ThrReset;
			cfg_q.attack_rate <= AttackReset;
			cfg_q.release_rate <= ReleaseReset;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_THRESHOLD: cfg_q.threshold <= cfg_data[ThrW-1:0];
				REG_ATTACK:    cfg_q.attack_rate <= cfg_data;
				REG_RELEASE:   cfg_q.release_rate <= cfg_data;
				default:       cfg_q <= cfg_q;
			endcase
		end
	end

endmodule

// File: rtl/mng_serial_mult.sv
module mng_serial_mult
	import mng_pkg::*;
#(
	parameter int unsigned MCAND_W = 25,
	parameter int unsigned MPLIER_W = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [MCAND_W-1:0]  mcand,
	input  logic [MPLIER_W-1:0] mplier,
	output logic [MCAND_W-1:0]  prod_hi,
	output logic [MPLIER_W-1:0] prod_lo,
	output mult_stat_t          stat
);

	localparam int unsigned CntW = (MPLIER_W > 1) ? $clog2(MPLIER_W) : 1;
	localparam logic [CntW-1:0] LastCnt = CntW'(MPLIER_W - 1);

	logic [MCAND_W-1:0]  mcand_q;
	logic [MCAND_W-1:0]  hi_q;
	logic [MPLIER_W-1:0] lo_q;
	logic [CntW-1:0]     cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [MCAND_W:0]    sum;

	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == LastCnt) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mcand;
			hi_q <= '0;
			lo_q <= mplier;
		end else if (busy_q) begin
			hi_q <= sum[MCAND_W:1];
			lo_q <= {sum[0], lo_q[MPLIER_W-1:1]};
		end
	end

	assign prod_hi = hi_q;
	assign prod_lo = lo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// File: rtl/mic_sample_noise_gate.sv
// Noise gate for a microphone sample stream.
// Input channel: one 32-bit I2S frame per transfer on raw_frame; bits 31:16 form
// the signed 16-bit sample. A transfer happens when in_valid is high and in_stall
// is low. Output channel: one gated 16-bit sample per input transfer, moved when
// out_valid is high and out_stall is low.
// Configuration writes use cfg_valid/cfg_ready with cfg_index selecting the
// threshold, attack rate or release rate; cfg_ready is always high.
// One bit-serial shift-add multiplier does both products: first the gain update
// (gap to one times a rate when the sample reaches the threshold, else gain
// times the release rate, one rate bit per cycle), then the output (sample
// magnitude times the new gain). in_stall stays high from each input transfer
// until its result is loaded into the output register.
// The output register holds a finished sample while the receiver stalls; the
// next item is still taken and computed, and it waits in the multiplier until
// the output register is free.
// Reset closes the gate (gain zero), restores the default registers and
// empties the output register.
module mic_sample_noise_gate
	import mng_pkg::*;
#(
	parameter int unsigned GAIN_FRAC_BITS = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [FrameW-1:0]        raw_frame,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [SampleW-1:0] gated_sample,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CfgIdxW-1:0]       cfg_index,
	input  logic [RateFracBits-1:0]  cfg_data
);

	localparam int unsigned GainW = GAIN_FRAC_BITS + 1;
	localparam logic [GainW-1:0] GainOne = {1'b1, {GAIN_FRAC_BITS{1'b0}}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_OUT
	} state_t;

	state_t                 state_q;
	cfg_t                   cfg;
	mult_stat_t             mult_stat;
	logic [GainW-1:0]       gain_q;
	logic [MagW-1:0]        mag_q;
	logic                   sneg_q;
	logic                   dneg_q;
	logic                   out_valid_q;
	logic [SampleW-1:0]     out_data_q;
	logic [MagW-1:0]        mag_c;
	logic                   open_c;
	logic                   start_c;
	logic [GainW-1:0]       mcand_c;
	logic [RateFracBits-1:0] mplier_c;
	logic [GainW-1:0]       prod_hi;
	logic [RateFracBits-1:0] prod_lo;
	logic                   sticky;
	logic [GainW:0]         gain_wide;
	logic [GainW-1:0]       gain_next;
	logic [GainW+RateFracBits-1:0] prod_full;
	logic [MagW-1:0]        res_mag;
	logic [MagW-1:0]        res_c;
	logic                   accept_in;
	logic                   out_free;
	logic                   out_load;

	mng_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mng_serial_mult #(
		.MCAND_W  (GainW),
		.MPLIER_W (RateFracBits)
	) u_mult (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_c),
		.mcand   (mcand_c),
		.mplier  (mplier_c),
		.prod_hi (prod_hi),
		.prod_lo (prod_lo),
		.stat    (mult_stat)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign accept_in = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == ST_OUT) && !mult_stat.busy && out_free;

	assign mag_c = raw_frame[FrameW-1] ? (MagW'(0) - {1'b1, raw_frame[FrameW-1 -: SampleW]})
		: {1'b0, raw_frame[FrameW-1 -: SampleW]};
	assign open_c = (mag_c >= {1'b0, cfg.threshold});

	assign sticky = (prod_lo != '0);
	assign gain_wide = dneg_q ? ({1'b0, gain_q} - {1'b0, prod_hi} - (GainW+1)'(sticky))
		: ({1'b0, gain_q} + {1'b0, prod_hi});
	assign gain_next = gain_wide[GainW-1:0];

	assign prod_full = {prod_hi, prod_lo};
	assign res_mag = prod_full[GAIN_FRAC_BITS+SampleW -: MagW];
	assign res_c = sneg_q ? (MagW'(0) - res_mag) : res_mag;

	always_comb begin
		start_c = 1'b0;
		mcand_c = gain_next;
		mplier_c = RateFracBits'(mag_q);
		case (state_q)
			ST_IDLE: begin
				start_c = accept_in;
				if (open_c) begin
					mcand_c = GainOne - gain_q;
					mplier_c = (gain_q != GainOne) ? cfg.attack_rate : cfg.release_rate;
				end else begin
					mcand_c = gain_q;
					mplier_c = cfg.release_rate;
				end
			end
			ST_UPD: start_c = mult_stat.done;
			default: start_c = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			gain_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_data_q <= res_c[SampleW-1:0];
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept_in) begin
						mag_q <= mag_c;
						sneg_q <= raw_frame[FrameW-1];
						dneg_q <= !open_c;
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (mult_stat.done) begin
						gain_q <= gain_next;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign gated_sample = out_data_q;

	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		accept_in |=> in_stall && mult_stat.busy)
		else $error("input transfer did not start the multiplier");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mult_stat.busy && !mult_stat.done)
		else $error("multiplier active while idle");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		gain_q <= GainOne)
		else $error("gain above one");

	a_done_finish: assert property (@(posedge clk) disable iff (!arst_n)
		mult_stat.done |-> !mult_stat.busy && $past(mult_stat.busy))
		else $error("multiplier done without a finished pass");

endmodule
